// ===== src/lyp_pkg.sv =====
// ---------------------------------------------------------------------------
// lyp_pkg: shared types and constants for the look-at yaw/pitch unit
// Widths of the normalized and CORDIC datapaths, the arctangent table and
// the CORDIC micro-rotation used by both vectoring chains.
// ---------------------------------------------------------------------------
package lyp_pkg;

    // normalized differences: sign plus up to 48 magnitude bits
    localparam int NORM_W     = 49;
    // leading one is moved up to this bit
    localparam int NORM_MSB   = 47;
    // shift steps of 32, 16, 8, 4, 2, 1
    localparam int NORM_STEPS = 6;

    // CORDIC x/y width; covers gain and sqrt(2) growth over a 2^48 input
    localparam int CORD_W     = 54;

    localparam int TAB_LEN    = 24;
    localparam int TAB_IDX_W  = 5;

    localparam int GAIN_W     = 24;
    localparam logic [GAIN_W-1:0] INV_GAIN_Q24 = 24'd10188014;

    localparam logic [31:0] HALF_TURN = 32'h8000_0000;

    // atan(2^-i) with 2^32 as a full turn
    localparam logic [31:0] ATAN_TAB [TAB_LEN] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81
    };

    typedef struct packed {
        logic degenerate;
        logic dx_zero;
        logic dy_zero;
        logic dz_neg;
    } t_flags;

    typedef struct packed {
        logic signed [CORD_W-1:0] x;
        logic signed [CORD_W-1:0] y;
        logic        [31:0]       z;
    } t_cord;

    // yaw chain stage: rotation state plus what the pitch half needs later
    typedef struct packed {
        t_cord                    c;
        logic signed [NORM_W-1:0] dy;
        t_flags                   f;
    } t_yaw_stg;

    // pitch chain stage: rotation state plus the finished yaw angle
    typedef struct packed {
        t_cord       c;
        logic [31:0] yaw_z;
        t_flags      f;
    } t_pitch_stg;

    // one vectoring micro-rotation, drives y toward zero
    function automatic t_cord cord_step(input t_cord c, input logic [TAB_IDX_W-1:0] idx);
        t_cord                    r;
        logic signed [CORD_W-1:0] xs;
        logic signed [CORD_W-1:0] ys;
        xs = c.x >>> idx;
        ys = c.y >>> idx;
        if (!c.y[CORD_W-1]) begin
            r.x = c.x + ys;
            r.y = c.y - xs;
            r.z = c.z + ATAN_TAB[idx];
        end else begin
            r.x = c.x - ys;
            r.y = c.y + xs;
            r.z = c.z - ATAN_TAB[idx];
        end
        return r;
    endfunction

    function automatic logic [NORM_W-1:0] mag(input logic signed [NORM_W-1:0] v);
        return v[NORM_W-1] ? NORM_W'(-v) : NORM_W'(v);
    endfunction

endpackage

// ===== src/lyp_in_if.sv =====
// ---------------------------------------------------------------------------
// lyp_in_if: position pair channel
// Entity and camera coordinates, signed fixed point, valid/ready handshake.
// ---------------------------------------------------------------------------
interface lyp_in_if #(
    parameter int COORD_BITS = 32
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] entity_x;
    logic signed [COORD_BITS-1:0] entity_y;
    logic signed [COORD_BITS-1:0] entity_z;
    logic signed [COORD_BITS-1:0] camera_x;
    logic signed [COORD_BITS-1:0] camera_y;
    logic signed [COORD_BITS-1:0] camera_z;

    modport source (
        output valid, entity_x, entity_y, entity_z, camera_x, camera_y, camera_z,
        input  ready
    );
    modport sink (
        input  valid, entity_x, entity_y, entity_z, camera_x, camera_y, camera_z,
        output ready
    );
endinterface

// ===== src/lyp_out_if.sv =====
// ---------------------------------------------------------------------------
// lyp_out_if: angle result channel
// Pitch and yaw binary angles plus the degenerate flag, valid/ready handshake.
// ---------------------------------------------------------------------------
interface lyp_out_if #(
    parameter int ANGLE_BITS = 16
) ();
    logic                         valid;
    logic                         ready;
    logic signed [ANGLE_BITS-1:0] pitch_angle;
    logic signed [ANGLE_BITS-1:0] yaw_angle;
    logic                         degenerate;

    modport source (
        output valid, pitch_angle, yaw_angle, degenerate,
        input  ready
    );
    modport sink (
        input  valid, pitch_angle, yaw_angle, degenerate,
        output ready
    );
endinterface

// ===== src/look_at_yaw_pitch_unit.sv =====
// ---------------------------------------------------------------------------
// look_at_yaw_pitch_unit: yaw and pitch that turn an entity toward a camera
// Takes entity and camera positions on i_item and returns, on o_result, the
// pitch and yaw binary angles (2^(ANGLE_BITS-1) is pi) and a degenerate flag.
//
// Each accepted item gives exactly one result, in order. The pipeline takes
// one item per cycle while the skid register is empty. Its registers are,
// in order: difference, magnitude, six stages of binary normalizing shift,
// pre-rotation, the yaw CORDIC vectoring chain (one register per
// micro-rotation), two gain-correction multiply stages, the pitch CORDIC
// vectoring chain and the output register.
// The output register is backed by a skid register; i_item.ready is driven
// from the skid valid register and drops only while the skid holds an item.
// A stall that fills the skid freezes the pipeline, losing or repeating nothing.
// Reset clears the valid bits only; there is no other state and no
// configuration.
// ---------------------------------------------------------------------------
module look_at_yaw_pitch_unit
    import lyp_pkg::*;
#(
    parameter int COORD_BITS    = 32,
    parameter int ANGLE_BITS    = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lyp_in_if.sink    i_item,
    lyp_out_if.source o_result
);

    localparam int              ASH   = 32 - ANGLE_BITS;
    localparam logic [31:0]     ROUND = 32'd1 << (ASH - 1);
    localparam int              HI_W  = CORD_W - 25;
    localparam int              PHI_W = HI_W + GAIN_W;
    localparam int              PLO_W = 2 * GAIN_W;

    typedef struct packed {
        logic signed [ANGLE_BITS-1:0] pitch;
        logic signed [ANGLE_BITS-1:0] yaw;
        logic                         deg;
    } t_res;

    logic en;

    // ---------------- stage A: differences ----------------
    logic                     r_a_vld;
    logic signed [NORM_W-1:0] r_a_dx, r_a_dy, r_a_dz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_dx <= NORM_W'(signed'(i_item.camera_x[COORD_BITS-1:0]))
                      - NORM_W'(signed'(i_item.entity_x[COORD_BITS-1:0]));
            r_a_dy <= NORM_W'(signed'(i_item.camera_y[COORD_BITS-1:0]))
                      - NORM_W'(signed'(i_item.entity_y[COORD_BITS-1:0]));
            r_a_dz <= NORM_W'(signed'(i_item.camera_z[COORD_BITS-1:0]))
                      - NORM_W'(signed'(i_item.entity_z[COORD_BITS-1:0]));
        end
    end

    // ---------------- stage B: magnitude and flags ----------------
    logic                     r_b_vld;
    logic        [NORM_W-1:0] r_b_m;
    logic signed [NORM_W-1:0] r_b_dx, r_b_dy, r_b_dz;
    t_flags                   r_b_flg;
    t_flags                   n_b_flg;

    // OR of magnitudes has the same leading one as their maximum
    always_comb begin
        n_b_flg.dx_zero    = (r_a_dx == '0);
        n_b_flg.dy_zero    = (r_a_dy == '0);
        n_b_flg.dz_neg     = r_a_dz[NORM_W-1];
        n_b_flg.degenerate = (r_a_dx == '0) && (r_a_dz == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_m   <= mag(r_a_dx) | mag(r_a_dy) | mag(r_a_dz);
            r_b_dx  <= r_a_dx;
            r_b_dy  <= r_a_dy;
            r_b_dz  <= r_a_dz;
            r_b_flg <= n_b_flg;
        end
    end

    // ---------------- normalizing shift, one power of two per stage ----------------
    logic                     r_n_vld [NORM_STEPS];
    logic        [NORM_W-1:0] r_n_m   [NORM_STEPS];
    logic signed [NORM_W-1:0] r_n_dx  [NORM_STEPS];
    logic signed [NORM_W-1:0] r_n_dy  [NORM_STEPS];
    logic signed [NORM_W-1:0] r_n_dz  [NORM_STEPS];
    t_flags                   r_n_flg [NORM_STEPS];

    for (genvar j = 0; j < NORM_STEPS; j++) begin : g_norm
        localparam int SH = 1 << (NORM_STEPS - 1 - j);

        logic                     vld_in;
        logic        [NORM_W-1:0] m_in;
        logic signed [NORM_W-1:0] dx_in, dy_in, dz_in;
        t_flags                   flg_in;
        logic                     take;

        if (j == 0) begin : g_first
            assign vld_in = r_b_vld;
            assign m_in   = r_b_m;
            assign dx_in  = r_b_dx;
            assign dy_in  = r_b_dy;
            assign dz_in  = r_b_dz;
            assign flg_in = r_b_flg;
        end else begin : g_next
            assign vld_in = r_n_vld[j-1];
            assign m_in   = r_n_m[j-1];
            assign dx_in  = r_n_dx[j-1];
            assign dy_in  = r_n_dy[j-1];
            assign dz_in  = r_n_dz[j-1];
            assign flg_in = r_n_flg[j-1];
        end

        // shift only if the leading one stays at or below NORM_MSB
        assign take = ((m_in >> (NORM_MSB + 1 - SH)) == '0);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_n_vld[j] <= 1'b0;
            end else if (en) begin
                r_n_vld[j] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_n_m[j]   <= take ? (m_in << SH)  : m_in;
                r_n_dx[j]  <= take ? (dx_in << SH) : dx_in;
                r_n_dy[j]  <= take ? (dy_in << SH) : dy_in;
                r_n_dz[j]  <= take ? (dz_in << SH) : dz_in;
                r_n_flg[j] <= flg_in;
            end
        end
    end

    // ---------------- stage P: fold into the right half-plane ----------------
    logic     r_p_vld;
    t_yaw_stg r_p;
    t_yaw_stg n_p;

    always_comb begin
        n_p.dy = r_n_dy[NORM_STEPS-1];
        n_p.f  = r_n_flg[NORM_STEPS-1];
        if (r_n_flg[NORM_STEPS-1].dz_neg) begin
            n_p.c.x = -CORD_W'(r_n_dz[NORM_STEPS-1]);
            n_p.c.y = -CORD_W'(r_n_dx[NORM_STEPS-1]);
            n_p.c.z = HALF_TURN;
        end else begin
            n_p.c.x = CORD_W'(r_n_dz[NORM_STEPS-1]);
            n_p.c.y = CORD_W'(r_n_dx[NORM_STEPS-1]);
            n_p.c.z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (en) begin
            r_p_vld <= r_n_vld[NORM_STEPS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p <= n_p;
        end
    end

    // ---------------- yaw vectoring chain ----------------
    logic     r_y_vld [CORDIC_STAGES];
    t_yaw_stg r_y     [CORDIC_STAGES];

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_yaw
        logic     vld_in;
        t_yaw_stg s_in;

        if (i == 0) begin : g_first
            assign vld_in = r_p_vld;
            assign s_in   = r_p;
        end else begin : g_next
            assign vld_in = r_y_vld[i-1];
            assign s_in   = r_y[i-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_y_vld[i] <= 1'b0;
            end else if (en) begin
                r_y_vld[i] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_y[i].c  <= cord_step(s_in.c, TAB_IDX_W'(i));
                r_y[i].dy <= s_in.dy;
                r_y[i].f  <= s_in.f;
            end
        end
    end

    // ---------------- gain correction: h = x / K ----------------
    logic             r_h1_vld;
    logic [PHI_W-1:0] r_h1_phi;
    logic [PLO_W-1:0] r_h1_plo;
    logic signed [NORM_W-1:0] r_h1_dy;
    logic [31:0]      r_h1_yaw;
    t_flags           r_h1_flg;

    logic       r_h2_vld;
    t_pitch_stg r_h2;
    t_pitch_stg n_h2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h1_vld <= 1'b0;
            r_h2_vld <= 1'b0;
        end else if (en) begin
            r_h1_vld <= r_y_vld[CORDIC_STAGES-1];
            r_h2_vld <= r_h1_vld;
        end
    end

    // x is never negative, so its upper bits multiply as unsigned
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h1_phi <= PHI_W'(r_y[CORDIC_STAGES-1].c.x[CORD_W-2:GAIN_W])
                        * PHI_W'(INV_GAIN_Q24);
            r_h1_plo <= PLO_W'(r_y[CORDIC_STAGES-1].c.x[GAIN_W-1:0]) * PLO_W'(INV_GAIN_Q24);
            r_h1_dy  <= r_y[CORDIC_STAGES-1].dy;
            r_h1_yaw <= r_y[CORDIC_STAGES-1].c.z;
            r_h1_flg <= r_y[CORDIC_STAGES-1].f;
        end
    end

    always_comb begin
        n_h2.c.x   = CORD_W'(r_h1_phi) + CORD_W'(r_h1_plo[PLO_W-1:GAIN_W]);
        n_h2.c.y   = CORD_W'(r_h1_dy);
        n_h2.c.z   = '0;
        n_h2.yaw_z = r_h1_yaw;
        n_h2.f     = r_h1_flg;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h2 <= n_h2;
        end
    end

    // ---------------- pitch vectoring chain ----------------
    logic       r_q_vld [CORDIC_STAGES];
    t_pitch_stg r_q     [CORDIC_STAGES];

    for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_pitch
        logic       vld_in;
        t_pitch_stg s_in;

        if (i == 0) begin : g_first
            assign vld_in = r_h2_vld;
            assign s_in   = r_h2;
        end else begin : g_next
            assign vld_in = r_q_vld[i-1];
            assign s_in   = r_q[i-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_q_vld[i] <= 1'b0;
            end else if (en) begin
                r_q_vld[i] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_q[i].c     <= cord_step(s_in.c, TAB_IDX_W'(i));
                r_q[i].yaw_z <= s_in.yaw_z;
                r_q[i].f     <= s_in.f;
            end
        end
    end

    // ---------------- special cases and rounding ----------------
    t_pitch_stg  q_last;
    logic [31:0] pitch_z;
    logic [31:0] yaw_z;
    t_res        n_res;
    logic        last_vld;

    assign q_last   = r_q[CORDIC_STAGES-1];
    assign last_vld = r_q_vld[CORDIC_STAGES-1];

    always_comb begin
        pitch_z = q_last.f.dy_zero ? 32'd0 : 32'd0 - q_last.c.z;
        if (q_last.f.dx_zero) begin
            yaw_z = q_last.f.dz_neg ? HALF_TURN : 32'd0;
        end else begin
            yaw_z = q_last.yaw_z;
        end
        n_res.pitch = ANGLE_BITS'((pitch_z + ROUND) >> ASH);
        n_res.yaw   = ANGLE_BITS'((yaw_z + ROUND) >> ASH);
        n_res.deg   = q_last.f.degenerate;
        if (q_last.f.degenerate) begin
            n_res.pitch = '0;
            n_res.yaw   = '0;
        end
    end

    // ---------------- output register with skid ----------------
    logic r_o_vld, r_s_vld;
    t_res r_o, r_s;

    assign en           = !r_s_vld;
    assign i_item.ready = !r_s_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
            r_s_vld <= 1'b0;
        end else if (r_s_vld) begin
            if (o_result.ready) begin
                r_s_vld <= 1'b0;
            end
        end else if (!r_o_vld || o_result.ready) begin
            r_o_vld <= last_vld;
        end else if (last_vld) begin
            r_s_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s_vld) begin
            if (o_result.ready) begin
                r_o <= r_s;
            end
        end else if (!r_o_vld || o_result.ready) begin
            r_o <= n_res;
        end else begin
            r_s <= n_res;
        end
    end

    assign o_result.valid       = r_o_vld;
    assign o_result.pitch_angle = r_o.pitch;
    assign o_result.yaw_angle   = r_o.yaw;
    assign o_result.degenerate  = r_o.deg;

endmodule

// ===== tb/tb.sv =====
// ---------------------------------------------------------------------------
// tb: self-checking bench for look_at_yaw_pitch_unit
// Sends entity/camera position pairs, predicts pitch, yaw and the degenerate
// flag with a bit-exact CORDIC model, and checks every result in order while
// both handshakes idle and stall at random.
// ---------------------------------------------------------------------------
module tb;

    localparam int COORD_BITS    = 32;
    localparam int ANGLE_BITS    = 16;
    localparam int CORDIC_STAGES = 16;

    localparam int LATENCY     = 2 * CORDIC_STAGES + 12;
    localparam int TAIL_CYCLES = LATENCY + 20;
    localparam int HOLD_AT     = 150;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;
    localparam int N_RANDOM    = 400;

    localparam logic signed [31:0] C_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] C_MIN = 32'sh8000_0000;

    localparam logic [31:0] PI_CODE    = 32'h8000_0000;
    localparam longint      NORM_FLOOR = 64'sd1 <<< 47;
    localparam longint      RECIP_GAIN = 64'sd10188014;

    // atan(2^-i), one full turn is 2^32
    localparam logic [31:0] ARCTAN [16] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861
    };

    typedef struct {
        logic signed [COORD_BITS-1:0] ex;
        logic signed [COORD_BITS-1:0] ey;
        logic signed [COORD_BITS-1:0] ez;
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic signed [COORD_BITS-1:0] cz;
    } t_pos;

    typedef struct {
        t_pos        pos;
        bit          drain;
        int unsigned gap;
    } t_pending;

    typedef struct {
        logic signed [ANGLE_BITS-1:0] pitch;
        logic signed [ANGLE_BITS-1:0] yaw;
        logic                         degenerate;
    } t_angles;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lyp_in_if  #(.COORD_BITS(COORD_BITS)) pos_ch ();
    lyp_out_if #(.ANGLE_BITS(ANGLE_BITS)) ang_ch ();

    look_at_yaw_pitch_unit #(
        .COORD_BITS    (COORD_BITS),
        .ANGLE_BITS    (ANGLE_BITS),
        .CORDIC_STAGES (CORDIC_STAGES)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (pos_ch),
        .o_result (ang_ch)
    );

    always #5 i_clk = ~i_clk;

    t_pending positions_pending[$];
    t_angles  angles_due[$];
    t_pos     cur_pos;
    int       n_items;
    int       items_taken = 0;
    int       n_results   = 0;
    int       n_errors    = 0;
    int       idle_cycles = 0;
    int       tx_wait     = 0;
    int       rx_wait     = 0;

    // ---------------------------------------------------------------------
    // prediction
    // ---------------------------------------------------------------------
    function automatic longint magnitude(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // vectoring rotation: drives y to zero, returns the accumulated angle
    function automatic logic [31:0] rotate_to_axis(input longint x0, input longint y0,
                                                   input logic [31:0] z0,
                                                   output longint x_fin);
        longint      x;
        longint      y;
        longint      xs;
        longint      ys;
        logic [31:0] z;
        x = x0;
        y = y0;
        z = z0;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + ARCTAN[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - ARCTAN[i];
            end
        end
        x_fin = x;
        return z;
    endfunction

    function automatic logic signed [ANGLE_BITS-1:0] to_binary_angle(input logic [31:0] z);
        logic [31:0] r;
        r = z + (32'd1 << (31 - ANGLE_BITS));
        return r[31 -: ANGLE_BITS];
    endfunction

    function automatic t_angles aim_angles(input t_pos p);
        t_angles     a;
        longint      dx;
        longint      dy;
        longint      dz;
        longint      m;
        longint      x;
        longint      y;
        longint      xr;
        longint      h;
        longint      unused_x;
        logic [31:0] z;
        logic [31:0] yaw_z;
        logic [31:0] pitch_z;
        int          s;
        dx = longint'(p.cx) - longint'(p.ex);
        dy = longint'(p.cy) - longint'(p.ey);
        dz = longint'(p.cz) - longint'(p.ez);
        if (dx == 0 && dz == 0) begin
            a.pitch      = '0;
            a.yaw        = '0;
            a.degenerate = 1'b1;
            return a;
        end
        m = magnitude(dx);
        if (magnitude(dy) > m) m = magnitude(dy);
        if (magnitude(dz) > m) m = magnitude(dz);
        s = 0;
        while (m != 0 && m < NORM_FLOOR) begin
            m = m <<< 1;
            s++;
        end
        dx = dx <<< s;
        dy = dy <<< s;
        dz = dz <<< s;

        // rotate into the right half-plane first when dz points backward
        x = dz;
        y = dx;
        z = '0;
        if (dz < 0) begin
            x = -dz;
            y = -dx;
            z = PI_CODE;
        end
        yaw_z = rotate_to_axis(x, y, z, xr);
        if (dx == 0) yaw_z = (dz < 0) ? PI_CODE : 32'd0;

        h = (xr >>> 24) * RECIP_GAIN + (((xr & 64'hFF_FFFF) * RECIP_GAIN) >>> 24);

        if (dy == 0) pitch_z = '0;
        else pitch_z = 32'd0 - rotate_to_axis(h, dy, 32'd0, unused_x);

        a.pitch      = to_binary_angle(pitch_z);
        a.yaw        = to_binary_angle(yaw_z);
        a.degenerate = 1'b0;
        return a;
    endfunction

    // ---------------------------------------------------------------------
    // stimulus building
    // ---------------------------------------------------------------------
    task automatic add_item(input t_pos p, input bit drain);
        t_pending it;
        int       idx;
        idx      = positions_pending.size();
        it.pos   = p;
        it.drain = drain;
        // every third block of 40 items goes back to back
        it.gap   = ((idx / 40) % 3 == 1) ? 0 : $urandom_range(0, 8);
        positions_pending.push_back(it);
    endtask

    task automatic add_pos(input logic signed [31:0] ex, input logic signed [31:0] ey,
                           input logic signed [31:0] ez, input logic signed [31:0] cx,
                           input logic signed [31:0] cy, input logic signed [31:0] cz);
        t_pos p;
        p.ex = ex; p.ey = ey; p.ez = ez;
        p.cx = cx; p.cy = cy; p.cz = cz;
        add_item(p, 1'b0);
    endtask

    function automatic logic signed [31:0] near(input logic signed [31:0] base, input int r);
        int off;
        off = int'($urandom_range(0, 2 * r)) - r;
        return base + off;
    endfunction

    task automatic add_random(input bit drain);
        t_pos p;
        int   r;
        int   kind;
        p.ex = $urandom;
        p.ey = $urandom;
        p.ez = $urandom;
        kind = $urandom_range(0, 9);
        if (kind < 5) begin
            p.cx = $urandom;
            p.cy = $urandom;
            p.cz = $urandom;
        end else begin
            case ($urandom_range(0, 3))
                0:       r = 1;
                1:       r = 255;
                2:       r = 1 << 16;
                default: r = 1 << 24;
            endcase
            p.cx = near(p.ex, r);
            p.cy = near(p.ey, r);
            p.cz = near(p.ez, r);
        end
        // zero components reach the axis and degenerate cases
        if ($urandom_range(0, 5) == 0) p.cx = p.ex;
        if ($urandom_range(0, 5) == 0) p.cz = p.ez;
        if ($urandom_range(0, 7) == 0) p.cy = p.ey;
        add_item(p, drain);
    endtask

    // ---------------------------------------------------------------------
    // position driver
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin : pos_driver
        if (!i_rst_n) begin
            pos_ch.valid    <= 1'b0;
            pos_ch.entity_x <= '0;
            pos_ch.entity_y <= '0;
            pos_ch.entity_z <= '0;
            pos_ch.camera_x <= '0;
            pos_ch.camera_y <= '0;
            pos_ch.camera_z <= '0;
            tx_wait = 0;
        end else begin
            if (pos_ch.valid && pos_ch.ready) begin
                angles_due.push_back(aim_angles(cur_pos));
                items_taken++;
                if (positions_pending.size() != 0) tx_wait = positions_pending[0].gap;
            end
            if ((pos_ch.valid && pos_ch.ready) || !pos_ch.valid) begin
                if (tx_wait != 0) begin
                    tx_wait--;
                    pos_ch.valid <= 1'b0;
                end else if (positions_pending.size() != 0 &&
                             !(positions_pending[0].drain && angles_due.size() != 0)) begin
                    cur_pos = positions_pending[0].pos;
                    positions_pending.delete(0);
                    pos_ch.entity_x <= cur_pos.ex;
                    pos_ch.entity_y <= cur_pos.ey;
                    pos_ch.entity_z <= cur_pos.ez;
                    pos_ch.camera_x <= cur_pos.cx;
                    pos_ch.camera_y <= cur_pos.cy;
                    pos_ch.camera_z <= cur_pos.cz;
                    pos_ch.valid    <= 1'b1;
                end else begin
                    pos_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // result monitor
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin : angle_monitor
        t_angles want;
        if (!i_rst_n) begin
            ang_ch.ready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (ang_ch.valid && ang_ch.ready) begin
                n_results++;
                if (angles_due.size() == 0) begin
                    $error("result with no item outstanding");
                    n_errors++;
                end else begin
                    want = angles_due.pop_front();
                    if (ang_ch.pitch_angle !== want.pitch) begin
                        $error("pitch_angle: expected %0d, got %0d",
                               want.pitch, ang_ch.pitch_angle);
                        n_errors++;
                    end
                    if (ang_ch.yaw_angle !== want.yaw) begin
                        $error("yaw_angle: expected %0d, got %0d",
                               want.yaw, ang_ch.yaw_angle);
                        n_errors++;
                    end
                    if (ang_ch.degenerate !== want.degenerate) begin
                        $error("degenerate: expected %0b, got %0b",
                               want.degenerate, ang_ch.degenerate);
                        n_errors++;
                    end
                end
                // one long hold-off lets the pipeline fill and push back
                if (n_results == HOLD_AT) rx_wait = HOLD_CYCLES;
                else if ((n_results / 50) % 3 == 2) rx_wait = 0;
                else rx_wait = $urandom_range(0, 8);
            end else if (rx_wait != 0) begin
                rx_wait--;
            end
            ang_ch.ready <= (rx_wait == 0);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (pos_ch.valid && pos_ch.ready) || (ang_ch.valid && ang_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ---------------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------------
    initial begin
        i_rst_n = 1'b0;

        // directed corners
        add_pos(0, 0, 0, 0, 0, 0);
        add_pos(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX);
        add_pos(C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN);
        add_pos(C_MIN, C_MAX, C_MIN, C_MAX, C_MIN, C_MAX);
        add_pos(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX);
        add_pos(5, C_MIN, 7, 5, C_MAX, 7);
        add_pos(100, 0, 0, 100, 3 << 16, 1 << 16);
        add_pos(100, 0, 0, 100, -(3 << 16), -(1 << 16));
        add_pos(100, 9, 0, 100, 9, -(1 << 16));
        add_pos(100, 9, C_MIN, 100, 9, C_MAX);
        add_pos(0, 42, 0, 1 << 16, 42, 1 << 16);
        add_pos(0, 0, 0, 1, 0, 0);
        add_pos(0, 0, 0, -1, 1, 0);
        add_pos(0, 0, C_MAX, 1, 0, C_MIN);
        add_pos(0, 0, C_MAX, -1, 0, C_MIN);
        add_pos(0, 0, 0, 1, 1, 1);
        add_pos(C_MIN, 0, 0, C_MAX, 0, 1);
        add_pos(0, C_MIN, 0, 1, C_MAX, 0);
        add_pos(0, C_MAX, 0, 1, C_MIN, 0);
        add_pos(C_MIN, 1, C_MIN, C_MAX, 0, C_MAX);
        add_pos(-1, -1, -1, 0, 0, 0);
        add_pos(0, 0, 0, -1, -1, -1);
        add_pos(-1, C_MAX, 2, -1, C_MIN, 2);

        // sender waits for an empty pipeline at the first random item and at item 250
        for (int i = 0; i < N_RANDOM; i++)
            add_random(i == 0 || i == 250);
        n_items = positions_pending.size();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while ((items_taken < n_items || angles_due.size() != 0) && idle_cycles < STALL_LIMIT)
            @(posedge i_clk);

        if (idle_cycles >= STALL_LIMIT) begin
            $error("no handshake for %0d cycles", STALL_LIMIT);
            $display("tb: done, errors");
        end else begin
            repeat (TAIL_CYCLES) @(posedge i_clk);
            if (n_errors == 0)
                $display("tb: done, clean");
            else
                $display("tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== look_at_yaw_pitch_unit.f =====
src/lyp_pkg.sv
src/lyp_in_if.sv
src/lyp_out_if.sv
src/look_at_yaw_pitch_unit.sv
tb/tb.sv
